>>> rtl/bmh_pkg.sv
// ----------------------------------------------------------------------------
// bmh_pkg: shared types and constants of the binary min-heap core
// sizes of the key store, sequencer states, status codes and the
// store port bundle
// ----------------------------------------------------------------------------
`default_nettype none

package bmh_pkg;

   localparam int CAPACITY = 256;
   localparam int ADDR_W   = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int KEY_W    = 32;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_REMOVE = 1'b1;

   typedef enum logic [1:0] {
      STAT_DONE  = 2'd0,
      STAT_FULL  = 2'd1,
      STAT_EMPTY = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_UP_RD,
      ST_UP_CMP,
      ST_RM_TOP,
      ST_RM_LAST,
      ST_DN_RD,
      ST_DN_LEFT,
      ST_DN_RIGHT,
      ST_DN_CMP
   } state_type;

   typedef struct packed {
      logic [ADDR_W-1:0] rd_addr;
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [KEY_W-1:0]  wr_data;
   } store_req_type;

   typedef struct packed {
      logic              valid;
      logic [KEY_W-1:0]  min_value;
      status_type        status;
   } result_type;

endpackage

`default_nettype wire

>>> rtl/bmh_store.sv
// ----------------------------------------------------------------------------
// bmh_store: key store of the heap
// one write port and one read port, read data registered
// ----------------------------------------------------------------------------
`default_nettype none

module bmh_store (
   input  wire logic                          clock,
   input  wire bmh_pkg::store_req_type        store_req,
   output logic [bmh_pkg::KEY_W-1:0]          rd_data
);

   logic [bmh_pkg::KEY_W-1:0] mem [bmh_pkg::CAPACITY];

   always_ff @(posedge clock) begin
      if (store_req.wr_en) begin
         mem[store_req.wr_addr] <= store_req.wr_data;
      end
      rd_data <= mem[store_req.rd_addr];
   end

endmodule

`default_nettype wire

>>> rtl/bmh_ctrl.sv
// ----------------------------------------------------------------------------
// bmh_ctrl: sift sequencer of the heap
// walks sift-up and sift-down one level at a time through a single
// signed key comparator, driving the key store ports
// ----------------------------------------------------------------------------
`default_nettype none

module bmh_ctrl (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_accept,
   input  wire logic                          req_operation,
   input  wire logic [bmh_pkg::KEY_W-1:0]     req_value,
   input  wire logic [bmh_pkg::KEY_W-1:0]     rd_data,
   output bmh_pkg::store_req_type             store_req,
   output bmh_pkg::result_type                result,
   output logic                               busy
);

   localparam int CNT_W  = bmh_pkg::CNT_W;
   localparam int ADDR_W = bmh_pkg::ADDR_W;
   localparam int KEY_W  = bmh_pkg::KEY_W;

   bmh_pkg::state_type state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   pos_ff, pos_in;
   logic [CNT_W-1:0]   cpos_ff, cpos_in;
   logic [KEY_W-1:0]   key_ff, key_in;      // insert key, or last entry on remove
   logic [KEY_W-1:0]   top_ff, top_in;
   logic [KEY_W-1:0]   left_ff, left_in;
   logic [KEY_W-1:0]   child_ff, child_in;

   logic [KEY_W-1:0]   cmp_a, cmp_b;
   logic               cmp_gt;
   logic [CNT_W:0]     pos2;
   logic [CNT_W-1:0]   pos_m1;

   // shared signed comparator
   assign cmp_gt = $signed(cmp_a) > $signed(cmp_b);
   assign pos2   = {pos_ff, 1'b0};
   assign pos_m1 = pos_ff - CNT_W'(1);
   assign busy   = (state_ff != bmh_pkg::ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bmh_pkg::ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff   <= pos_in;
      cpos_ff  <= cpos_in;
      key_ff   <= key_in;
      top_ff   <= top_in;
      left_ff  <= left_in;
      child_ff <= child_in;
   end

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      pos_in    = pos_ff;
      cpos_in   = cpos_ff;
      key_in    = key_ff;
      top_in    = top_ff;
      left_in   = left_ff;
      child_in  = child_ff;
      cmp_a     = key_ff;
      cmp_b     = child_ff;
      store_req = '{rd_addr: '0, wr_en: 1'b0, wr_addr: pos_m1[ADDR_W-1:0], wr_data: key_ff};
      result    = '{valid: 1'b0, min_value: '0, status: bmh_pkg::STAT_DONE};

      unique case (state_ff)
         bmh_pkg::ST_IDLE: begin
            // root read is always issued here for a remove
            if (req_accept) begin
               if (req_operation == bmh_pkg::OP_INSERT) begin
                  if (count_ff == CNT_W'(bmh_pkg::CAPACITY)) begin
                     result.valid  = 1'b1;
                     result.status = bmh_pkg::STAT_FULL;
                  end else begin
                     key_in   = req_value;
                     pos_in   = count_ff + CNT_W'(1);
                     state_in = bmh_pkg::ST_UP_RD;
                  end
               end else begin
                  if (count_ff == '0) begin
                     result.valid  = 1'b1;
                     result.status = bmh_pkg::STAT_EMPTY;
                  end else begin
                     state_in = bmh_pkg::ST_RM_TOP;
                  end
               end
            end
         end

         bmh_pkg::ST_UP_RD: begin
            if (pos_ff == CNT_W'(1)) begin
               store_req.wr_en = 1'b1;
               count_in        = count_ff + CNT_W'(1);
               result.valid    = 1'b1;
               state_in        = bmh_pkg::ST_IDLE;
            end else begin
               store_req.rd_addr = ADDR_W'((pos_ff >> 1) - CNT_W'(1));
               state_in          = bmh_pkg::ST_UP_CMP;
            end
         end

         bmh_pkg::ST_UP_CMP: begin
            cmp_a = rd_data;
            cmp_b = key_ff;
            store_req.wr_en = 1'b1;
            if (cmp_gt) begin
               // parent moves down one level
               store_req.wr_data = rd_data;
               pos_in            = pos_ff >> 1;
               state_in          = bmh_pkg::ST_UP_RD;
            end else begin
               count_in     = count_ff + CNT_W'(1);
               result.valid = 1'b1;
               state_in     = bmh_pkg::ST_IDLE;
            end
         end

         bmh_pkg::ST_RM_TOP: begin
            top_in            = rd_data;
            store_req.rd_addr = ADDR_W'(count_ff - CNT_W'(1));
            count_in          = count_ff - CNT_W'(1);
            state_in          = bmh_pkg::ST_RM_LAST;
         end

         bmh_pkg::ST_RM_LAST: begin
            key_in   = rd_data;
            pos_in   = CNT_W'(1);
            state_in = bmh_pkg::ST_DN_RD;
         end

         bmh_pkg::ST_DN_RD: begin
            // count_ff already holds the reduced size here
            if (pos2 > {1'b0, count_ff}) begin
               store_req.wr_en  = (count_ff != '0);
               result.valid     = 1'b1;
               result.min_value = top_ff;
               state_in         = bmh_pkg::ST_IDLE;
            end else begin
               store_req.rd_addr = ADDR_W'(pos2 - (CNT_W+1)'(1));
               state_in          = bmh_pkg::ST_DN_LEFT;
            end
         end

         bmh_pkg::ST_DN_LEFT: begin
            left_in = rd_data;
            if (pos2 < {1'b0, count_ff}) begin
               store_req.rd_addr = ADDR_W'(pos2);
               state_in          = bmh_pkg::ST_DN_RIGHT;
            end else begin
               // only a left child
               child_in = rd_data;
               cpos_in  = CNT_W'(pos2);
               state_in = bmh_pkg::ST_DN_CMP;
            end
         end

         bmh_pkg::ST_DN_RIGHT: begin
            // left wins ties
            cmp_a = left_ff;
            cmp_b = rd_data;
            if (cmp_gt) begin
               child_in = rd_data;
               cpos_in  = CNT_W'(pos2 + (CNT_W+1)'(1));
            end else begin
               child_in = left_ff;
               cpos_in  = CNT_W'(pos2);
            end
            state_in = bmh_pkg::ST_DN_CMP;
         end

         bmh_pkg::ST_DN_CMP: begin
            cmp_a = key_ff;
            cmp_b = child_ff;
            store_req.wr_en = 1'b1;
            if (cmp_gt) begin
               store_req.wr_data = child_ff;
               pos_in            = cpos_ff;
               state_in          = bmh_pkg::ST_DN_RD;
            end else begin
               result.valid     = 1'b1;
               result.min_value = top_ff;
               state_in         = bmh_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = bmh_pkg::ST_IDLE;
         end
      endcase
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(bmh_pkg::CAPACITY))
      else $error("entry count above capacity");

   a_full_refusal: assert property (@(posedge clock) disable iff (reset)
      result.valid && result.status == bmh_pkg::STAT_FULL
      |-> count_ff == CNT_W'(bmh_pkg::CAPACITY))
      else $error("insert refused while heap not full");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      result.valid && (state_ff == bmh_pkg::ST_UP_RD || state_ff == bmh_pkg::ST_UP_CMP)
      |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("finished insert did not grow the heap");

   a_idle_no_write: assert property (@(posedge clock) disable iff (reset)
      state_ff == bmh_pkg::ST_IDLE |-> !store_req.wr_en)
      else $error("store written while idle");

endmodule

`default_nettype wire

>>> rtl/binary_min_heap_core.sv
// ----------------------------------------------------------------------------
// binary_min_heap_core: priority queue of signed 32-bit keys
// binary min-heap in a single-port-read key store, with insert and
// remove-min commands and one registered result per command
// ----------------------------------------------------------------------------
// A command transfers when start is high and busy is low. Every command gives
// exactly one result, shown for one cycle with rsp_valid high; the receiver
// cannot stall it, so it must take the result in that cycle. Both commands
// walk the heap one level at a time, paced by the one-read-per-cycle key
// store: each level an insert climbs is a parent read, a compare in the
// shared comparator and a write; each level a remove-min descends is one or
// two child reads, compares in the shared comparator and a write. A refused
// command (insert into a full heap, remove from an empty one) answers in the
// next cycle and leaves the heap unchanged; busy stays low for it. The result
// is registered, so it lands in the cycle after the sequencer finishes, and a
// new command may transfer in that same cycle.
`default_nettype none

module binary_min_heap_core (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic                          req_operation,
   input  wire logic signed [31:0]            req_value,
   output logic                               rsp_valid,
   output logic signed [31:0]                 rsp_min_value,
   output logic [1:0]                         rsp_status
);

   bmh_pkg::store_req_type          store_req;
   bmh_pkg::result_type             result;
   logic [bmh_pkg::KEY_W-1:0]       rd_data;
   logic                            req_accept;

   // result register
   logic                            rsp_valid_ff;
   logic [bmh_pkg::KEY_W-1:0]       rsp_min_value_ff;
   bmh_pkg::status_type             rsp_status_ff;

   // command transfer
   assign req_accept = start && !busy;

   // sequencer with the shared comparator
   bmh_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_accept    (req_accept),
      .req_operation (req_operation),
      .req_value     (req_value),
      .rd_data       (rd_data),
      .store_req     (store_req),
      .result        (result),
      .busy          (busy)
   );

   // key store
   bmh_store u_store (
      .clock     (clock),
      .store_req (store_req),
      .rd_data   (rd_data)
   );

   // strobe needs reset, payload does not
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= result.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (result.valid) begin
         rsp_min_value_ff <= result.min_value;
         rsp_status_ff    <= result.status;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_min_value = rsp_min_value_ff;
   assign rsp_status    = rsp_status_ff;

endmodule

`default_nettype wire

>>> tb/binary_min_heap_core_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_min_heap_core_checker: shadow heap and result scoreboard
// keeps its own min-heap of the keys, works out the answer owed for every
// command transfer and compares each result transfer against the oldest one
// ----------------------------------------------------------------------------

module binary_min_heap_core_checker (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic               busy,
   input  wire logic               req_operation,
   input  wire logic signed [31:0] req_value,
   input  wire logic               rsp_valid,
   input  wire logic signed [31:0] rsp_min_value,
   input  wire logic [1:0]         rsp_status,
   output int                      fault_count,
   output int                      pending_count
);

   typedef struct packed {
      logic signed [bmh_pkg::KEY_W-1:0] min_value;
      bmh_pkg::status_type              status;
   } answer_type;

   logic signed [bmh_pkg::KEY_W-1:0] shadow_keys [bmh_pkg::CAPACITY];
   int                               shadow_count;
   answer_type                       owed_answers [$];
   answer_type                       oldest;

   // positions are 1-based, position p lives in shadow_keys[p-1]
   function automatic answer_type apply_heap_command(
      input logic                             op,
      input logic signed [bmh_pkg::KEY_W-1:0] key);
      answer_type                       ans;
      logic signed [bmh_pkg::KEY_W-1:0] moving;
      int                               slot;
      int                               child;
      int                               remaining;
      logic                             settled;
      ans.min_value = '0;
      ans.status    = bmh_pkg::STAT_DONE;
      if (op == bmh_pkg::OP_INSERT) begin
         if (shadow_count >= bmh_pkg::CAPACITY) begin
            ans.status = bmh_pkg::STAT_FULL;
         end else begin
            // climb past strictly larger parents only
            slot = shadow_count + 1;
            while (slot > 1 && shadow_keys[slot/2 - 1] > key) begin
               shadow_keys[slot - 1] = shadow_keys[slot/2 - 1];
               slot = slot / 2;
            end
            shadow_keys[slot - 1] = key;
            shadow_count++;
         end
      end else if (shadow_count == 0) begin
         ans.status = bmh_pkg::STAT_EMPTY;
      end else begin
         ans.min_value = shadow_keys[0];
         moving        = shadow_keys[shadow_count - 1];
         remaining     = shadow_count - 1;
         slot          = 1;
         settled       = 1'b0;
         while (!settled && 2 * slot <= remaining) begin
            child = 2 * slot;
            // left child wins a tie
            if (child < remaining && shadow_keys[child - 1] > shadow_keys[child])
               child++;
            if (moving > shadow_keys[child - 1]) begin
               shadow_keys[slot - 1] = shadow_keys[child - 1];
               slot = child;
            end else begin
               settled = 1'b1;
            end
         end
         if (remaining > 0)
            shadow_keys[slot - 1] = moving;
         shadow_count = remaining;
      end
      return ans;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         shadow_count = 0;
         owed_answers.delete();
      end else begin
         // a result transfer always belongs to an earlier command
         if (rsp_valid) begin
            if (owed_answers.size() == 0) begin
               $error("result with nothing owed: min_value %0d, status %0d",
                      rsp_min_value, rsp_status);
               fault_count++;
            end else begin
               oldest = owed_answers.pop_front();
               if (rsp_min_value !== oldest.min_value) begin
                  $error("min_value mismatch: expected %0d, actual %0d",
                         oldest.min_value, rsp_min_value);
                  fault_count++;
               end
               if (rsp_status !== oldest.status) begin
                  $error("status mismatch: expected %0d, actual %0d",
                         oldest.status, rsp_status);
                  fault_count++;
               end
            end
         end
         if (start && !busy)
            owed_answers = {owed_answers, apply_heap_command(req_operation, req_value)};
      end
      pending_count <= owed_answers.size();
   end

endmodule

>>> tb/binary_min_heap_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_min_heap_core_tb: command-level test of the min-heap core
// directed corner commands, then fill and drain sweeps and mixed traffic
// under varying sender gaps; a checker beside the core scores every result
// ----------------------------------------------------------------------------

module binary_min_heap_core_tb;

   localparam int WATCHDOG_LIMIT = 2000;   // quiet cycles before giving up
   localparam int SETTLE_CYCLES  = 60;     // longer than the slowest remove-min
   localparam int MAX_GAP        = 20;     // longest sender pause per command

   logic               clock;
   logic               reset         = 1'b1;
   logic               start         = 1'b0;
   logic               req_operation = bmh_pkg::OP_INSERT;
   logic signed [31:0] req_value     = '0;
   logic               busy;
   logic               rsp_valid;
   logic signed [31:0] rsp_min_value;
   logic [1:0]         rsp_status;

   int fault_count;
   int pending_count;

   // stimulus bookkeeping: how full the heap is and what was sent
   int keys_held;
   int idle_pct;
   int inserts_sent;
   int removes_sent;
   int full_refusals;
   int empty_refusals;
   int quiet_cycles;

   binary_min_heap_core dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_operation (req_operation),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_min_value (rsp_min_value),
      .rsp_status    (rsp_status)
   );

   binary_min_heap_core_checker checker_i (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_operation (req_operation),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_min_value (rsp_min_value),
      .rsp_status    (rsp_status),
      .fault_count   (fault_count),
      .pending_count (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // watchdog: any cycle without a command or result transfer counts
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
         $display("binary_min_heap_core_tb: errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // key mix: full-range values, a narrow band full of ties, and the extremes
   function automatic logic signed [31:0] pick_key();
      int narrow;
      narrow = $urandom_range(15);
      case ($urandom_range(3))
         0:       return narrow - 8;
         1: begin
            case ($urandom_range(3))
               0:       return 32'sh8000_0000;
               1:       return 32'sh7FFF_FFFF;
               2:       return 32'sd0;
               default: return -32'sd1;
            endcase
         end
         default: return $urandom;
      endcase
   endfunction

   // one command transfer; start stays high across back-to-back commands
   task automatic issue_command(input logic op, input logic signed [31:0] key);
      int gap;
      gap = 0;
      while (gap < MAX_GAP && $urandom_range(99) < idle_pct)
         gap++;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start         <= 1'b1;
      req_operation <= op;
      req_value     <= key;
      @(posedge clock);
      while (busy) @(posedge clock);
      // the transfer happened at this edge
      if (op == bmh_pkg::OP_INSERT) begin
         if (keys_held >= bmh_pkg::CAPACITY) begin
            full_refusals++;
         end else begin
            keys_held++;
            inserts_sent++;
         end
      end else begin
         if (keys_held == 0) begin
            empty_refusals++;
         end else begin
            keys_held--;
            removes_sent++;
         end
      end
   endtask

   // sender holds off until every owed result has shown up
   task automatic drain_results();
      start <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   // run the heap up to full and past it, then down to empty and past it
   task automatic fill_and_drain(input int bias_pct);
      int   refused;
      logic op;
      refused = 0;
      while (refused < 4) begin
         op = ($urandom_range(99) < bias_pct) ? bmh_pkg::OP_INSERT : bmh_pkg::OP_REMOVE;
         if (op == bmh_pkg::OP_INSERT && keys_held >= bmh_pkg::CAPACITY)
            refused++;
         issue_command(op, pick_key());
      end
      refused = 0;
      while (refused < 4) begin
         op = ($urandom_range(99) < bias_pct) ? bmh_pkg::OP_REMOVE : bmh_pkg::OP_INSERT;
         if (op == bmh_pkg::OP_REMOVE && keys_held == 0)
            refused++;
         issue_command(op, pick_key());
      end
   endtask

   task automatic mixed_traffic(input int count, input int insert_pct);
      repeat (count)
         issue_command(($urandom_range(99) < insert_pct) ? bmh_pkg::OP_INSERT
                                                         : bmh_pkg::OP_REMOVE,
                       pick_key());
   endtask

   initial begin
      keys_held = 0;
      idle_pct  = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: empty remove, extreme keys, keys near zero, equal keys,
      // alternating bit patterns, then drain past empty with junk in the value field
      issue_command(bmh_pkg::OP_REMOVE, 32'sh1234_5678);
      issue_command(bmh_pkg::OP_INSERT, 32'sh7FFF_FFFF);
      issue_command(bmh_pkg::OP_INSERT, 32'sh8000_0000);
      issue_command(bmh_pkg::OP_INSERT, 32'sd0);
      issue_command(bmh_pkg::OP_INSERT, -32'sd1);
      issue_command(bmh_pkg::OP_INSERT, 32'sd1);
      issue_command(bmh_pkg::OP_INSERT, 32'sd5);
      issue_command(bmh_pkg::OP_INSERT, 32'sd5);
      issue_command(bmh_pkg::OP_INSERT, 32'sd5);
      issue_command(bmh_pkg::OP_INSERT, 32'shAAAA_AAAA);
      issue_command(bmh_pkg::OP_INSERT, 32'sh5555_5555);
      repeat (11)
         issue_command(bmh_pkg::OP_REMOVE, $urandom);
      issue_command(bmh_pkg::OP_REMOVE, 32'shFFFF_FFFF);
      drain_results();

      // back-to-back commands through a full sweep
      fill_and_drain(95);
      drain_results();

      // sender pauses before most commands
      idle_pct = 63;
      fill_and_drain(95);
      drain_results();

      // moderate gaps, traffic that hovers near empty
      idle_pct = 30;
      mixed_traffic(100, 60);
      drain_results();

      idle_pct = 0;
      mixed_traffic(80, 50);
      drain_results();

      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("run covered %0d inserts and %0d remove-mins, full and empty heap",
               inserts_sent, removes_sent);
      $display("refusals seen: %0d on a full heap, %0d on an empty heap",
               full_refusals, empty_refusals);
      if (fault_count == 0 && pending_count == 0) begin
         $display("binary_min_heap_core_tb: clean");
      end else begin
         $display("binary_min_heap_core_tb: errors");
      end
      $finish;
   end

endmodule

>>> binary_min_heap_core.f
rtl/bmh_pkg.sv
rtl/bmh_store.sv
rtl/bmh_ctrl.sv
rtl/binary_min_heap_core.sv
tb/binary_min_heap_core_checker.sv
tb/binary_min_heap_core_tb.sv
